// ===== hdl/fth_pkg.sv =====
// Shared constants and types of the flow tuple hash table.
package fth_pkg;

  localparam int SLOT_W = 10;
  localparam int SLOTS  = 2 ** SLOT_W;

  localparam int WORD_W  = 128;
  localparam int KEY_W   = 96;
  localparam int FIELD_W = 16;

  localparam logic [FIELD_W-1:0] EMPTY_CID = 16'hFFFF;

  localparam logic [1:0] STAT_HIT      = 2'd0;
  localparam logic [1:0] STAT_MISS     = 2'd1;
  localparam logic [1:0] STAT_INSERTED = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic step;
    logic wr;
    logic out_load;
  } fth_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic match;
    logic last_probe;
    logic ins_write;
  } fth_sts_t;

endpackage

// ===== hdl/fth_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fth_ctrl.sv =====
// Controller state machine: clearing pass, request intake, probe sequencing.
module fth_ctrl
  import fth_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  fth_sts_t sts_i,
  output fth_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       done;

  assign out_free = !out_valid_q || out_ready_i;
  assign done     = sts_i.empty || sts_i.match || sts_i.last_probe;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (done) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.wr       = sts_i.ins_write;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/fth_dpath.sv =====
// Datapath: key register, hash, probe counters, slot store and result register.
module fth_dpath
  import fth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fth_cmd_t            cmd_i,
  output fth_sts_t            sts_o,
  input  logic [1:0]          in_user_i,
  input  logic [WORD_W-1:0]   in_data_i,
  output logic [1:0]          out_status_o,
  output logic [FIELD_W-1:0]  out_cid_o
);

  logic [WORD_W-1:0]  key_q;
  logic               is_ins_q;
  logic               use_dir_q;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0]  clr_q;
  logic [1:0]         status_q;
  logic [FIELD_W-1:0] cid_q;

  logic [WORD_W-1:0]  key_d;
  logic [31:0]        hash;
  logic [FIELD_W-1:0] dir_in;
  logic [WORD_W-1:0]  rd_word;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic [WORD_W-1:0]  wdata;
  logic               key_eq;
  logic               empty;
  logic               match;
  logic               last_probe;
  logic [1:0]         status_d;

  // tdata: src_addr, dst_addr, src_port, dst_port, direction, new_cid
  assign dir_in = in_user_i[1] ? in_data_i[111:96] : EMPTY_CID;
  assign key_d  = {in_data_i[127:112], dir_in, in_data_i[95:0]};
  assign hash   = in_data_i[31:0] | in_data_i[63:32]
                | {16'd0, in_data_i[79:64]} | {16'd0, in_data_i[95:80]}
                | (in_user_i[1] ? {16'd0, in_data_i[111:96]} : 32'd0);
  assign idx_d  = hash[SLOT_W-1:0];

  assign we    = cmd_i.clr || cmd_i.wr;
  assign waddr = cmd_i.clr ? clr_q : idx_q;
  assign wdata = cmd_i.clr ? {WORD_W{1'b1}} : key_q;

  fth_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rd_word)
  );

  assign empty      = rd_word[127:112] == EMPTY_CID;
  assign key_eq     = (rd_word[KEY_W-1:0] == key_q[KEY_W-1:0])
                   && (!use_dir_q || rd_word[111:96] == key_q[111:96]);
  assign match      = !is_ins_q && key_eq;
  assign last_probe = &cnt_q;

  always_comb begin
    if (empty) begin
      status_d = is_ins_q ? STAT_INSERTED : STAT_MISS;
    end else if (match) begin
      status_d = STAT_HIT;
    end else begin
      status_d = is_ins_q ? STAT_FULL : STAT_MISS;
    end
  end

  assign sts_o.clr_last   = &clr_q;
  assign sts_o.empty      = empty;
  assign sts_o.match      = match;
  assign sts_o.last_probe = last_probe;
  assign sts_o.ins_write  = empty && is_ins_q && (key_q[127:112] != EMPTY_CID);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= key_d;
      is_ins_q  <= in_user_i[0];
      use_dir_q <= in_user_i[1];
      idx_q     <= idx_d;
      cnt_q     <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      status_q <= status_d;
      cid_q    <= (!empty && match) ? rd_word[127:112] : EMPTY_CID;
    end
  end

  assign out_status_o = status_q;
  assign out_cid_o    = cid_q;

endmodule

// ===== hdl/flow_tuple_hash_table.sv =====
// Flow tuple hash table top level: maps a flow key to a connection id.
//
// Usage:
//   Slave channel s_axis carries one request: tuser holds the command
//   (lookup or insert) and the use-direction flag, tdata the flow key and
//   the connection id to insert. Master channel m_axis returns one result
//   per request: tuser the status (hit, miss, inserted, full), tdata the
//   connection id found on a hit, all ones otherwise.
//   The home slot is the OR of the key fields taken modulo the table size;
//   probing walks the slot store linearly through its single registered
//   read port, one slot per READ and CHECK pass, and stops after at most
//   SLOTS probes. A request is accepted only in the idle state, so the
//   block takes no new request before the last one has finished probing.
//   After reset a clearing pass writes every slot empty, one after another;
//   s_axis_tready_o stays low meanwhile.
//   Results sit in an output register: the next request is accepted while a
//   result waits, and the probe holds its last slot until m_axis is free.
module flow_tuple_hash_table
  import fth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // src_addr, dst_addr, src_port, dst_port, direction, new_cid
  input  logic [WORD_W-1:0]   s_axis_tdata_i,
  // cmd, use_dir
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // found_cid
  output logic [FIELD_W-1:0]  m_axis_tdata_o,
  // status
  output logic [1:0]          m_axis_tuser_o
);

  fth_cmd_t cmd;
  fth_sts_t sts;

  fth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fth_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_user_i    (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .out_status_o (m_axis_tuser_o),
    .out_cid_o    (m_axis_tdata_o)
  );

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded over a pending result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while previous one in flight");

  a_cid_on_hit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != STAT_HIT |-> m_axis_tdata_o == EMPTY_CID)
    else $error("connection id returned without a hit");

  a_no_write_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> cmd.out_load && sts.empty)
    else $error("slot written outside an insert completion");

endmodule

// ===== tb/tb.sv =====
// Testbench for the flow tuple hash table: random and directed lookups and inserts.
`timescale 1ns / 1ps

module tb
  import fth_pkg::*;
();

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam int RANDOM_REQUESTS = 600;
  localparam int DRAIN_CYCLES    = 2 * SLOTS + 16;
  localparam int CYCLE_LIMIT     = 10_000_000;

  // Field order follows tdata, first member in the top bits.
  typedef struct packed {
    logic [15:0] new_cid;
    logic [15:0] direction;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } flow_word_t;

  typedef struct packed {
    logic       use_dir;
    logic       cmd;
    flow_word_t word;
  } flow_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cid;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [FIELD_W-1:0]  m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  logic      req_valid = 1'b0;
  flow_req_t cur_req = '0;
  logic      res_ready = 1'b0;

  flow_word_t    slot_tab [SLOTS];
  flow_req_t     pending_requests_q [$];
  flow_req_t     stored_keys_q [$];
  table_result_t lookup_results_q [$];

  int filled = 0;
  int errors = 0;
  int sent = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int burst_left;
  int gap_left;
  logic [7:0] stall_pat = 8'hFF;
  int pat_age = 0;
  int unsigned cycle_count = 0;
  logic [SLOT_W-1:0] hot_homes [16];

  flow_tuple_hash_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (cur_req.word),
    .s_axis_tuser_i  ({cur_req.use_dir, cur_req.cmd}),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Linear probe from the home slot, at most SLOTS slots, updating slot_tab on insert.
  function automatic table_result_t resolve_request(flow_req_t r);
    logic [31:0]       h;
    logic [SLOT_W-1:0] idx;
    logic              done;
    logic              key_eq;
    table_result_t     res;
    h = r.word.src_addr | r.word.dst_addr | 32'(r.word.src_port) | 32'(r.word.dst_port)
        | (r.use_dir ? 32'(r.word.direction) : 32'd0);
    idx = h[SLOT_W-1:0];
    done = 1'b0;
    res.status = (r.cmd == CMD_INSERT) ? STAT_FULL : STAT_MISS;
    res.cid = EMPTY_CID;
    for (int n = 0; n < SLOTS && !done; n++) begin
      key_eq = slot_tab[idx].src_addr == r.word.src_addr
               && slot_tab[idx].dst_addr == r.word.dst_addr
               && slot_tab[idx].src_port == r.word.src_port
               && slot_tab[idx].dst_port == r.word.dst_port
               && (!r.use_dir || slot_tab[idx].direction == r.word.direction);
      if (slot_tab[idx].new_cid == EMPTY_CID) begin
        done = 1'b1;
        if (r.cmd == CMD_INSERT) begin
          res.status = STAT_INSERTED;
          if (r.word.new_cid != EMPTY_CID) begin
            slot_tab[idx] = r.word;
            if (!r.use_dir) slot_tab[idx].direction = EMPTY_CID;
          end
        end else begin
          res.status = STAT_MISS;
        end
      end else if (r.cmd == CMD_LOOKUP && key_eq) begin
        done = 1'b1;
        res.status = STAT_HIT;
        res.cid = slot_tab[idx].new_cid;
      end
      idx = idx + SLOT_W'(1);
    end
    return res;
  endfunction

  function automatic flow_req_t compose_request(logic cmd, logic use_dir, logic [31:0] sa,
                                                logic [31:0] da, logic [15:0] sp,
                                                logic [15:0] dp, logic [15:0] dir,
                                                logic [15:0] cid);
    flow_req_t r;
    r.cmd = cmd;
    r.use_dir = use_dir;
    r.word = '{new_cid: cid, direction: dir, dst_port: dp, src_port: sp,
               dst_addr: da, src_addr: sa};
    return r;
  endfunction

  // Key whose fields OR to the given home slot; wild keys are fully random.
  function automatic flow_req_t random_request(logic cmd, logic [SLOT_W-1:0] home,
                                               logic allow_wild);
    flow_req_t r;
    r.cmd = cmd;
    r.use_dir = 1'($urandom_range(0, 1));
    r.word.src_addr = $urandom();
    r.word.dst_addr = $urandom();
    r.word.src_port = 16'($urandom());
    r.word.dst_port = 16'($urandom());
    r.word.direction = 16'($urandom());
    r.word.new_cid = 16'($urandom_range(0, 16'hFFFE));
    if (!(allow_wild && $urandom_range(0, 7) == 0)) begin
      r.word.src_addr[SLOT_W-1:0] = home;
      r.word.dst_addr[SLOT_W-1:0] = home & SLOT_W'($urandom());
      r.word.src_port[SLOT_W-1:0] = home & SLOT_W'($urandom());
      r.word.dst_port[SLOT_W-1:0] = home & SLOT_W'($urandom());
      if (r.use_dir) r.word.direction[SLOT_W-1:0] = home & SLOT_W'($urandom());
    end
    return r;
  endfunction

  function automatic flow_req_t stored_lookup();
    flow_req_t r;
    r = stored_keys_q[$urandom_range(0, stored_keys_q.size() - 1)];
    r.cmd = CMD_LOOKUP;
    r.word.new_cid = 16'($urandom());
    return r;
  endfunction

  task automatic queue_request(flow_req_t r);
    pending_requests_q.push_back(r);
    if (r.cmd == CMD_INSERT && r.word.new_cid != EMPTY_CID && filled < SLOTS) begin
      filled++;
      stored_keys_q.push_back(r);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_valid && s_axis_tready_o) begin
        lookup_results_q.push_back(resolve_request(cur_req));
        sent++;
      end
      if (!req_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_requests_q.size() > 0) begin
          cur_req <= pending_requests_q.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 23);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a rotating pattern, reloaded whenever pat_age reaches 31.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      stall_pat <= 8'hFF;
      pat_age <= 0;
    end else begin
      if (m_axis_tvalid_o && res_ready) begin
        if (lookup_results_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d cid %h", $time, m_axis_tuser_o,
                   m_axis_tdata_o);
          errors++;
        end else begin
          if (m_axis_tuser_o !== lookup_results_q[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     lookup_results_q[0].status, m_axis_tuser_o);
            errors++;
          end
          if (m_axis_tdata_o !== lookup_results_q[0].cid) begin
            $display("%0t: found_cid expected %h actual %h", $time,
                     lookup_results_q[0].cid, m_axis_tdata_o);
            errors++;
          end
          status_seen[lookup_results_q[0].status]++;
          void'(lookup_results_q.pop_front());
        end
      end
      res_ready <= stall_pat[0];
      if (pat_age == 31) begin
        pat_age <= 0;
        stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom());
      end else begin
        pat_age <= pat_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               lookup_results_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    flow_req_t         r;
    int                sel;
    int                b;
    logic [SLOT_W-1:0] home;
    for (int i = 0; i < SLOTS; i++) slot_tab[i] = '1;
    for (int i = 0; i < 16; i++) hot_homes[i] = SLOT_W'($urandom());

    // empty table, then the all-zero key
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    queue_request(compose_request(CMD_INSERT, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF,
                                  16'hFFFF));
    // all-ones key lands in the last slot
    queue_request(compose_request(CMD_INSERT, 1'b1, '1, '1, '1, '1, '1, 16'hFFFE));
    // collides on the last slot and wraps past slot 0
    queue_request(compose_request(CMD_INSERT, 1'b0, 32'h3FF, 32'h0, 16'h0, 16'h0, 16'h1,
                                  16'h0001));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h3FF, 32'h0, 16'h0, 16'h0, 16'h0,
                                  16'h0));
    // reserved id leaves the store alone
    queue_request(compose_request(CMD_INSERT, 1'b0, 32'h5, 32'h0, 16'h0, 16'h0, 16'h0,
                                  EMPTY_CID));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h5, 32'h0, 16'h0, 16'h0, 16'h0,
                                  16'h0));
    // stored without direction: direction reads back as all ones
    queue_request(compose_request(CMD_INSERT, 1'b0, 32'h8000_0000, 32'h0001_0000, 16'h03FF,
                                  16'hFC00, 16'h5A5A, 16'h1234));
    queue_request(compose_request(CMD_LOOKUP, 1'b1, 32'h8000_0000, 32'h0001_0000, 16'h03FF,
                                  16'hFC00, 16'hFFFF, 16'h0));
    queue_request(compose_request(CMD_LOOKUP, 1'b1, 32'h8000_0000, 32'h0001_0000, 16'h03FF,
                                  16'hFC00, 16'h0000, 16'h0));
    // direction moves the home slot
    queue_request(compose_request(CMD_INSERT, 1'b1, 32'h10, 32'h0, 16'h0, 16'h0, 16'h0020,
                                  16'h0007));
    queue_request(compose_request(CMD_LOOKUP, 1'b1, 32'h10, 32'h0, 16'h0, 16'h0, 16'h0020,
                                  16'h0));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h10, 32'h0, 16'h0, 16'h0, 16'h0020,
                                  16'h0));
    // duplicate insert; lookup returns the first copy
    queue_request(compose_request(CMD_INSERT, 1'b0, 32'h8000_0000, 32'h0001_0000, 16'h03FF,
                                  16'hFC00, 16'h0, 16'h2222));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h8000_0000, 32'h0001_0000, 16'h03FF,
                                  16'hFC00, 16'h0, 16'h0));
    // stored with direction, looked up without
    queue_request(compose_request(CMD_INSERT, 1'b1, 32'h40, 32'h0, 16'h0, 16'h0, 16'h0040,
                                  16'hABCD));
    queue_request(compose_request(CMD_LOOKUP, 1'b0, 32'h40, 32'h0, 16'h0, 16'h0, 16'h0,
                                  16'h0));

    repeat (RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      home = ($urandom_range(0, 9) < 7) ? hot_homes[$urandom_range(0, 15)]
                                        : SLOT_W'($urandom());
      if (sel < 40) begin
        r = random_request(CMD_INSERT, home, 1'b1);
        if ($urandom_range(0, 31) == 0) r.word.new_cid = EMPTY_CID;
      end else if (sel < 75) begin
        r = stored_lookup();
        if ($urandom_range(0, 7) == 0) r.use_dir = ~r.use_dir;
      end else if (sel < 90) begin
        r = random_request(CMD_LOOKUP, home, 1'b1);
      end else begin
        r = stored_lookup();
        b = $urandom_range(0, 111);
        r.word[b] = ~r.word[b];
      end
      queue_request(r);
    end

    // closing mix of random keys and stored keys
    queue_request(random_request(CMD_LOOKUP, SLOT_W'($urandom()), 1'b1));
    queue_request(random_request(CMD_INSERT, SLOT_W'($urandom()), 1'b1));
    r = random_request(CMD_INSERT, SLOT_W'($urandom()), 1'b1);
    r.word.new_cid = EMPTY_CID;
    queue_request(r);
    queue_request(stored_lookup());
    r = stored_lookup();
    r.use_dir = ~r.use_dir;
    queue_request(r);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests_q.size() != 0 || req_valid) @(posedge clk_i);
    while (lookup_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests checked: %0d hits, %0d misses, %0d inserts, %0d full",
             sent, status_seen[STAT_HIT], status_seen[STAT_MISS],
             status_seen[STAT_INSERTED], status_seen[STAT_FULL]);
    $display("table filled to %0d of %0d slots, %0d errors", filled, SLOTS, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fth_pkg.sv
hdl/fth_ram.sv
hdl/fth_ctrl.sv
hdl/fth_dpath.sv
hdl/flow_tuple_hash_table.sv
tb/tb.sv
